FILE: hdl/afp_pkg.sv
package afp_pkg;

	localparam int PIX_W  = 8;
	localparam int IDX_W  = 17;
	localparam int TBL_W  = 8;
	localparam int FUNC_W = 2;

	// request codes on the func field
	localparam logic [FUNC_W-1:0] FUNC_PIXEL   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TABLE   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

	// queue sizing between and behind the two halves
	localparam int MID_DEPTH = 8;
	localparam int OUT_DEPTH = 8;
	localparam int CNT_W     = 4;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PIXEL,
		OP_TABLE,
		OP_RESTART
	} afp_op_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [PIX_W-1:0]  pixel_value;
		logic [IDX_W-1:0]  pixel_index;
		logic              frame_last;
		logic [TBL_W-1:0]  table_index;
		logic [PIX_W-1:0]  table_value;
	} afp_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic [IDX_W-1:0] out_index;
		logic             out_last;
	} afp_out_t;

	// classified request as it travels from the front to the back
	typedef struct packed {
		afp_op_t          op;
		logic [PIX_W-1:0] pixel_value;
		logic [IDX_W-1:0] pixel_index;
		logic [IDX_W-1:0] addr;
		logic             frame_last;
		logic [TBL_W-1:0] table_index;
		logic [PIX_W-1:0] table_value;
	} afp_cmd_t;

endpackage

FILE: hdl/afp_fifo.sv
module afp_fifo #(
	parameter int DEPTH = 8,
	parameter type T = logic,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  T              wdata,
	input  logic          pop,
	output T              rdata,
	output logic          empty,
	output logic [CW-1:0] count
);

	T               mem_q [DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_pop  = pop && !empty;
	assign do_push = push && (count_q < CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hdl/afp_front.sv
module afp_front #(
	parameter int MAX_PIXELS = 131072
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  afp_pkg::afp_in_t              item,
	input  logic [afp_pkg::CNT_W-1:0]     mid_count,
	output logic                          mid_push,
	output afp_pkg::afp_cmd_t             mid_cmd
);

	localparam int IW = afp_pkg::IDX_W;
	localparam bit WRAP = MAX_PIXELS < (1 << IW);
	localparam int LOG_M = $clog2(MAX_PIXELS);
	localparam int SHIFT = IW + LOG_M;
	localparam int RCP_W = IW + 1;
	localparam longint RCP =
		((longint'(1) << SHIFT) + longint'(MAX_PIXELS) - 1) / longint'(MAX_PIXELS);
	localparam int PRD_W = IW + RCP_W;
	localparam logic [RCP_W-1:0] RCP_V = RCP_W'(RCP);
	localparam logic [2*IW-1:0] MOD_V = (2*IW)'(MAX_PIXELS);

	logic                        accept;
	afp_pkg::afp_op_t            op_c;
	logic [afp_pkg::CNT_W-1:0]   occ;
	logic [PRD_W-1:0]            prd;
	logic [IW-1:0]               quo;
	logic [2*IW-1:0]             back_prd;
	logic [IW-1:0]               rem;

	logic                        v_s1;
	afp_pkg::afp_cmd_t           cmd_s1;
	logic                        v_s2;
	afp_pkg::afp_cmd_t           cmd_s2;
	logic [IW-1:0]               quo_s2;

	// count requests already in the front so the mid queue never overflows
	assign occ    = mid_count + afp_pkg::CNT_W'(v_s1) + afp_pkg::CNT_W'(v_s2);
	assign full   = (occ >= afp_pkg::CNT_W'(afp_pkg::MID_DEPTH));
	assign accept = push && !full;

	always_comb begin
		case (item.func)
			afp_pkg::FUNC_PIXEL:   op_c = afp_pkg::OP_PIXEL;
			afp_pkg::FUNC_TABLE:   op_c = afp_pkg::OP_TABLE;
			afp_pkg::FUNC_RESTART: op_c = afp_pkg::OP_RESTART;
			default:               op_c = afp_pkg::OP_NONE;
		endcase
	end

	// store address: index mod MAX_PIXELS by reciprocal, then back-multiply
	assign prd      = PRD_W'(cmd_s1.pixel_index) * PRD_W'(RCP_V);
	assign quo      = IW'(prd >> SHIFT);
	assign back_prd = (2*IW)'(quo_s2) * MOD_V;
	assign rem      = cmd_s2.pixel_index - back_prd[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1.op          <= op_c;
		cmd_s1.pixel_value <= item.pixel_value;
		cmd_s1.pixel_index <= item.pixel_index;
		cmd_s1.addr        <= item.pixel_index;
		cmd_s1.frame_last  <= item.frame_last;
		cmd_s1.table_index <= item.table_index;
		cmd_s1.table_value <= item.table_value;
		cmd_s2             <= cmd_s1;
		quo_s2             <= quo;
	end

	// drop unused codes here; everything else goes on to the back
	always_comb begin
		mid_cmd      = cmd_s2;
		mid_cmd.addr = WRAP ? rem : cmd_s2.pixel_index;
		mid_push     = v_s2 && (cmd_s2.op != afp_pkg::OP_NONE);
	end

endmodule

FILE: hdl/afp_back.sv
module afp_back #(
	parameter int MAX_PIXELS = 131072
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          mid_empty,
	input  afp_pkg::afp_cmd_t             mid_cmd,
	output logic                          mid_pop,
	input  logic [afp_pkg::CNT_W-1:0]     out_count,
	output logic                          out_push,
	output afp_pkg::afp_out_t             out_data
);

	localparam int IW = afp_pkg::IDX_W;
	localparam int PW = afp_pkg::PIX_W;
	localparam int DEPTH_S = (MAX_PIXELS < (1 << IW)) ? MAX_PIXELS : (1 << IW);
	localparam int AW = (DEPTH_S > 1) ? $clog2(DEPTH_S) : 1;
	localparam int TBL_DEPTH = 1 << afp_pkg::TBL_W;
	localparam logic [PW-1:0] PIX_MAX = {PW{1'b1}};

	function automatic logic [PW-1:0] div255_round(input logic [2*PW-1:0] x);
		logic [2*PW:0] y;
		logic [2*PW:0] t;
		y = (2*PW+1)'(x) + (2*PW+1)'(127);
		t = y + (2*PW+1)'(y[2*PW:PW]) + (2*PW+1)'(1);
		return t[2*PW-1:PW];
	endfunction

	logic [PW-1:0]             frame_mem [DEPTH_S];
	logic [PW-1:0]             alpha_mem [TBL_DEPTH];

	logic                      restart_q;
	logic                      lw_v_q;
	logic [IW-1:0]             lw_addr_q;
	logic [PW-1:0]             lw_data_q;

	logic                      head_pix;
	logic                      pv_s1;
	logic                      pv_s2;
	logic                      pv_s3;
	logic [afp_pkg::CNT_W-1:0] pend;
	logic                      room;
	logic                      hazard;
	logic                      issue;

	logic                      v_s1;
	afp_pkg::afp_cmd_t         cmd_s1;
	logic                      pass_s1;
	logic [PW-1:0]             frame_rd_s1;
	logic [PW-1:0]             p_c;
	logic [PW-1:0]             diff_c;

	logic                      v_s2;
	afp_pkg::afp_cmd_t         cmd_s2;
	logic                      pass_s2;
	logic [PW-1:0]             p_s2;
	logic [PW-1:0]             alpha_s2;
	logic [2*PW-1:0]           wp_c;
	logic [2*PW-1:0]           wi_c;

	logic                      v_s3;
	afp_pkg::afp_cmd_t         cmd_s3;
	logic                      pass_s3;
	logic [2*PW-1:0]           wp_s3;
	logic [2*PW-1:0]           wi_s3;
	logic [PW:0]               sum_c;
	logic [PW-1:0]             res_c;

	assign pv_s1 = v_s1 && (cmd_s1.op == afp_pkg::OP_PIXEL);
	assign pv_s2 = v_s2 && (cmd_s2.op == afp_pkg::OP_PIXEL);
	assign pv_s3 = v_s3 && (cmd_s3.op == afp_pkg::OP_PIXEL);

	// issue: reserve an output slot and hold while a close neighbor shares the address
	assign head_pix = (mid_cmd.op == afp_pkg::OP_PIXEL);
	assign pend     = out_count + afp_pkg::CNT_W'(pv_s1) + afp_pkg::CNT_W'(pv_s2)
		+ afp_pkg::CNT_W'(pv_s3);
	assign room     = (pend < afp_pkg::CNT_W'(afp_pkg::OUT_DEPTH));
	assign hazard   = (pv_s1 && (cmd_s1.addr == mid_cmd.addr))
		|| (pv_s2 && (cmd_s2.addr == mid_cmd.addr));
	assign issue    = !mid_empty && (!head_pix || (room && !hazard));
	assign mid_pop  = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q <= 1'b1;
		end else if (issue) begin
			if (mid_cmd.op == afp_pkg::OP_RESTART) begin
				restart_q <= 1'b1;
			end else if (head_pix && mid_cmd.frame_last) begin
				restart_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			lw_v_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (pv_s3) begin
				lw_v_q <= 1'b1;
			end
		end
	end

	// frame store: read on issue, write back from the last stage
	always_ff @(posedge clk) begin
		if (pv_s3) begin
			frame_mem[cmd_s3.addr[AW-1:0]] <= res_c;
		end
		if (issue) begin
			frame_rd_s1 <= frame_mem[mid_cmd.addr[AW-1:0]];
		end
	end

	// newest write bypasses a read that raced it
	assign p_c    = (lw_v_q && (lw_addr_q == cmd_s1.addr)) ? lw_data_q : frame_rd_s1;
	assign diff_c = (cmd_s1.pixel_value > p_c) ? (cmd_s1.pixel_value - p_c)
		: (p_c - cmd_s1.pixel_value);

	// alpha table: writes and reads both in stage 1 so order is kept
	always_ff @(posedge clk) begin
		if (v_s1 && (cmd_s1.op == afp_pkg::OP_TABLE)) begin
			alpha_mem[cmd_s1.table_index] <= cmd_s1.table_value;
		end
		alpha_s2 <= alpha_mem[diff_c];
	end

	assign wp_c = (2*PW)'(p_s2) * (2*PW)'(alpha_s2);
	assign wi_c = (2*PW)'(cmd_s2.pixel_value) * (2*PW)'(PIX_MAX - alpha_s2);

	assign sum_c = (PW+1)'(div255_round(wp_s3)) + (PW+1)'(div255_round(wi_s3));
	assign res_c = pass_s3 ? cmd_s3.pixel_value : (sum_c[PW] ? PIX_MAX : sum_c[PW-1:0]);

	always_ff @(posedge clk) begin
		cmd_s1  <= mid_cmd;
		pass_s1 <= restart_q;
		cmd_s2  <= cmd_s1;
		pass_s2 <= pass_s1;
		p_s2    <= p_c;
		cmd_s3  <= cmd_s2;
		pass_s3 <= pass_s2;
		wp_s3   <= wp_c;
		wi_s3   <= wi_c;
		if (pv_s3) begin
			lw_addr_q <= cmd_s3.addr;
			lw_data_q <= res_c;
		end
	end

	assign out_push           = pv_s3;
	assign out_data.out_pixel = res_c;
	assign out_data.out_index = cmd_s3.pixel_index;
	assign out_data.out_last  = cmd_s3.frame_last;

endmodule

FILE: hdl/adaptive_frame_persistence.sv
// Per-pixel recursive temporal filter for 8-bit frames. Push requests on
// the input queue: process a pixel, write one alpha table entry, or
// restart. A pixel is blended with the value stored at its position,
// weighted by the alpha entry picked by their absolute difference, then
// stored and returned on the result queue; while restarting, pixels pass
// through unchanged until the pixel marked last of frame. Load the table
// before sending pixels that need it: the frame store and the table have
// no reset and no clearing pass, so a never-written entry reads as junk.
// Throughput is one request per clock while full is low. Waits come from
// a full result queue and from the frame store read-modify-write loop: a
// pixel whose store address matches a pixel in back stage 1 or 2 holds
// until that pixel has moved on. Positions wrap modulo MAX_PIXELS;
// out_index still echoes pixel_index.
module adaptive_frame_persistence #(
	parameter int MAX_PIXELS = 131072
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  afp_pkg::afp_in_t   item,
	output logic               empty,
	input  logic               pop,
	output afp_pkg::afp_out_t  result
);

	logic                      mid_push;
	afp_pkg::afp_cmd_t         mid_wdata;
	logic                      mid_pop;
	afp_pkg::afp_cmd_t         mid_rdata;
	logic                      mid_empty;
	logic [afp_pkg::CNT_W-1:0] mid_count;

	logic                      out_push;
	afp_pkg::afp_out_t         out_wdata;
	logic [afp_pkg::CNT_W-1:0] out_count;

	// Front: accept, decode func, work out the store address.
	afp_front #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.mid_count(mid_count),
		.mid_push (mid_push),
		.mid_cmd  (mid_wdata)
	);

	// Decouple front and back so either side can stall alone.
	afp_fifo #(
		.DEPTH(afp_pkg::MID_DEPTH),
		.T    (afp_pkg::afp_cmd_t)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (mid_wdata),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.empty (mid_empty),
		.count (mid_count)
	);

	// Back: restart flag, frame store, alpha table, blend pipeline.
	afp_back #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_empty(mid_empty),
		.mid_cmd  (mid_rdata),
		.mid_pop  (mid_pop),
		.out_count(out_count),
		.out_push (out_push),
		.out_data (out_wdata)
	);

	// Hold finished results until the consumer pops them.
	afp_fifo #(
		.DEPTH(afp_pkg::OUT_DEPTH),
		.T    (afp_pkg::afp_out_t)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_wdata),
		.pop   (pop),
		.rdata (result),
		.empty (empty),
		.count (out_count)
	);

endmodule

FILE: hdl/afp_checker.sv
module afp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input logic              pop,
	input logic              empty,
	input afp_pkg::afp_out_t result
);

	// both queues come out of reset empty
	a_reset_state: assert property (@(posedge clk) !arst_n |=> (empty && !full))
		else $error("queues not cleared during reset");

	// backpressure only builds up from accepted requests
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full asserted without a preceding request");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result withdrawn");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(result))
		else $error("waiting result changed");

endmodule

bind adaptive_frame_persistence afp_checker u_afp_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.push  (push),
	.full  (full),
	.pop   (pop),
	.empty (empty),
	.result(result)
);

FILE: sim/tb.sv
module tb;
	import afp_pkg::*;

	localparam int STORE_DEPTH = 131072;
	localparam int POOL_SIZE = 32;
	localparam int POOL_W = $clog2(POOL_SIZE);
	// the fourth func code has no meaning; the block must drop it silently
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	afp_in_t item;
	logic empty;
	logic pop;
	afp_out_t result;

	adaptive_frame_persistence #(
		.MAX_PIXELS(STORE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Shadow copy of the filter state, advanced once per accepted request.
	logic [PIX_W-1:0] frame_mem [0:STORE_DEPTH-1];
	bit               frame_known [0:STORE_DEPTH-1];
	logic [PIX_W-1:0] alpha_mem [0:255];
	bit               restarting = 1'b1;
	afp_out_t         pending_results[$];
	int unsigned      pos_pool [POOL_SIZE];
	int               mismatch_count = 0;

	// Idling knobs shared by the sender tasks and the result sink.
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	int rx_hold_cycles = 0;

	// Gap length: mostly a short gap, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Filter one request into the shadow state; queue the pixel it returns.
	function automatic void predict_request(afp_in_t req);
		int unsigned slot;
		int unsigned prev;
		int unsigned cur;
		int unsigned diff;
		int unsigned alpha;
		int unsigned blended;
		afp_out_t    res;
		case (req.func)
			FUNC_TABLE: alpha_mem[req.table_index] = req.table_value;
			FUNC_RESTART: restarting = 1'b1;
			FUNC_PIXEL: begin
				slot = 32'(req.pixel_index) % STORE_DEPTH;
				cur = 32'(req.pixel_value);
				if (restarting) begin
					// pass through untouched while restarting
					blended = cur;
				end else begin
					prev = 32'(frame_mem[slot[IDX_W-1:0]]);
					diff = (prev > cur) ? prev - cur : cur - prev;
					alpha = 32'(alpha_mem[diff[TBL_W-1:0]]);
					// each weighted term rounds to nearest, the sum saturates
					blended = (prev * alpha + 127) / 255 + (cur * (255 - alpha) + 127) / 255;
					if (blended > 255)
						blended = 255;
				end
				frame_mem[slot[IDX_W-1:0]] = blended[PIX_W-1:0];
				frame_known[slot[IDX_W-1:0]] = 1'b1;
				if (req.frame_last)
					restarting = 1'b0;
				res.out_pixel = blended[PIX_W-1:0];
				res.out_index = req.pixel_index;
				res.out_last = req.frame_last;
				pending_results.push_back(res);
			end
			default: ; // unused code: no state change, no result
		endcase
	endfunction

	// Compare one popped pixel with the oldest prediction.
	function automatic void check_result(afp_out_t got);
		afp_out_t want;
		if (pending_results.size() == 0) begin
			$error("unexpected result: out_pixel %0d out_index %0d out_last %0d",
				got.out_pixel, got.out_index, got.out_last);
			mismatch_count++;
			return;
		end
		want = pending_results.pop_front();
		if (got.out_pixel !== want.out_pixel) begin
			$error("out_pixel: expected %0d, got %0d", want.out_pixel, got.out_pixel);
			mismatch_count++;
		end
		if (got.out_index !== want.out_index) begin
			$error("out_index: expected %0d, got %0d", want.out_index, got.out_index);
			mismatch_count++;
		end
		if (got.out_last !== want.out_last) begin
			$error("out_last: expected %0d, got %0d", want.out_last, got.out_last);
			mismatch_count++;
		end
	endfunction

	function automatic afp_in_t random_fields();
		afp_in_t req;
		req.func = FUNC_W'($urandom_range(0, 3));
		req.pixel_value = PIX_W'($urandom_range(0, 255));
		req.pixel_index = IDX_W'($urandom_range(0, STORE_DEPTH - 1));
		req.frame_last = 1'($urandom_range(0, 1));
		req.table_index = TBL_W'($urandom_range(0, 255));
		req.table_value = PIX_W'($urandom_range(0, 255));
		return req;
	endfunction

	// Unused fields of each request carry random junk on purpose.
	function automatic afp_in_t pixel_req(int unsigned value, int unsigned index, bit last);
		afp_in_t req;
		req = random_fields();
		req.func = FUNC_PIXEL;
		req.pixel_value = value[PIX_W-1:0];
		req.pixel_index = index[IDX_W-1:0];
		req.frame_last = last;
		return req;
	endfunction

	function automatic afp_in_t table_req(int unsigned index, int unsigned value);
		afp_in_t req;
		req = random_fields();
		req.func = FUNC_TABLE;
		req.table_index = index[TBL_W-1:0];
		req.table_value = value[PIX_W-1:0];
		return req;
	endfunction

	function automatic afp_in_t restart_req();
		afp_in_t req;
		req = random_fields();
		req.func = FUNC_RESTART;
		return req;
	endfunction

	function automatic afp_in_t unused_req();
		afp_in_t req;
		req = random_fields();
		req.func = FUNC_UNUSED;
		return req;
	endfunction

	// Pick a random pixel. Never aim a blending pixel at a position that
	// was never written: its stored value is junk in the block.
	function automatic afp_in_t random_pixel(bit last);
		int unsigned slot;
		int          value;
		int          pick;
		if (restarting && $urandom_range(0, 9) == 0)
			slot = $urandom_range(0, STORE_DEPTH - 1);
		else
			slot = pos_pool[POOL_W'($urandom_range(0, POOL_SIZE - 1))];
		if (!restarting && !frame_known[slot[IDX_W-1:0]])
			slot = pos_pool[0];
		pick = $urandom_range(0, 9);
		if (pick < 4 && frame_known[slot[IDX_W-1:0]]) begin
			// land close to the stored value to hit the low alpha entries
			value = int'(frame_mem[slot[IDX_W-1:0]]) + int'($urandom_range(0, 6)) - 3;
			if (value < 0)
				value = 0;
			if (value > 255)
				value = 255;
		end else if (pick == 4) begin
			value = 0;
		end else if (pick == 5) begin
			value = 255;
		end else begin
			value = $urandom_range(0, 255);
		end
		return pixel_req(value, slot, last);
	endfunction

	function automatic int unsigned random_weight();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// Offer one request from the falling edge; hold it until accepted.
	task automatic send_request(afp_in_t req);
		@(negedge clk);
		push <= 1'b1;
		item <= req;
		do
			@(posedge clk);
		while (full);
		predict_request(req);
	endtask

	task automatic sender_gap(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			push <= 1'b0;
		end
	endtask

	task automatic maybe_gap();
		if (tx_gaps && $urandom_range(0, 3) == 0)
			sender_gap(pick_gap());
	endtask

	// Drop push and wait until every predicted pixel has come back.
	task automatic drain_results();
		sender_gap(1);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// After reset the restart flag is set: the first frame must pass through.
	task automatic test_first_frame_passthrough();
		send_request(pixel_req(0, 0, 1'b0));
		send_request(pixel_req(255, STORE_DEPTH - 1, 1'b0));
		send_request(pixel_req(128, 1, 1'b0));
		send_request(pixel_req(1, 65536, 1'b1));
	endtask

	// Fill every alpha entry before anything can blend through it.
	task automatic test_table_load();
		int k;
		for (k = 0; k < 256; k++) begin
			send_request(table_req(k, random_weight()));
			maybe_gap();
		end
	endtask

	// Weights of zero and full scale, a half weight, and back-to-back
	// pixels on one position to exercise the store read-modify-write.
	task automatic test_blend_extremes();
		send_request(table_req(255, 0));
		send_request(table_req(0, 255));
		send_request(table_req(128, 128));
		send_request(table_req(1, 0));
		send_request(pixel_req(255, 0, 1'b0));
		send_request(pixel_req(0, STORE_DEPTH - 1, 1'b0));
		send_request(pixel_req(255, 0, 1'b0));
		send_request(pixel_req(0, 1, 1'b0));
		send_request(pixel_req(0, 65536, 1'b0));
		send_request(pixel_req(1, 65536, 1'b0));
		send_request(pixel_req(1, 65536, 1'b1));
	endtask

	// A restart in mid-frame passes the rest of the frame through; the
	// pixel marked last clears it and the next pixel blends again.
	task automatic test_restart_mid_frame();
		send_request(pixel_req(200, 1, 1'b0));
		send_request(restart_req());
		send_request(pixel_req(17, 0, 1'b0));
		send_request(pixel_req(99, STORE_DEPTH - 1, 1'b1));
		send_request(pixel_req(98, STORE_DEPTH - 1, 1'b0));
	endtask

	// The unused func code must leave no trace, whatever its other fields hold.
	task automatic test_unused_func();
		afp_in_t req;
		req = '1;
		send_request(req);
		send_request(unused_req());
		send_request(pixel_req(5, 0, 1'b1));
	endtask

	// Build the position pool and write every entry in one restart frame.
	task automatic seed_positions();
		int k;
		pos_pool[0] = 0;
		pos_pool[1] = STORE_DEPTH - 1;
		pos_pool[2] = 65536;
		pos_pool[3] = 1;
		for (k = 4; k < POOL_SIZE; k++)
			pos_pool[k[POOL_W-1:0]] = $urandom_range(0, STORE_DEPTH - 1);
		send_request(restart_req());
		for (k = 0; k < POOL_SIZE; k++) begin
			send_request(pixel_req($urandom_range(0, 255), pos_pool[k[POOL_W-1:0]],
				k == POOL_SIZE - 1));
			maybe_gap();
		end
	endtask

	// Mostly well-formed frames over a small pool of positions, with table
	// rewrites, restarts, stray frame ends and unused codes mixed in.
	task automatic test_random_frames(int count);
		int sent;
		int next_switch;
		int frame_len;
		int k;
		int pick;
		seed_positions();
		sent = 0;
		next_switch = 0;
		while (sent < count) begin
			if (sent >= next_switch) begin
				// switch idling on and off so stretches of full rate occur
				tx_gaps = $urandom_range(0, 2) != 0;
				rx_gaps = $urandom_range(0, 2) != 0;
				next_switch = sent + 50;
			end
			frame_len = $urandom_range(1, 16);
			for (k = 0; k < frame_len; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 6) begin
					send_request(table_req($urandom_range(0, 255), random_weight()));
					sent++;
				end else if (pick < 9) begin
					send_request(restart_req());
					sent++;
				end else if (pick < 12) begin
					send_request(unused_req());
				end else begin
					send_request(random_pixel(k == frame_len - 1 || pick >= 97));
					sent++;
				end
				maybe_gap();
			end
		end
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	// Hold off the receiver for a long stretch while requests keep coming,
	// so both queues fill up and the block asserts full.
	task automatic test_full_stall();
		int k;
		tx_gaps = 1'b0;
		rx_hold_cycles = 300;
		for (k = 0; k < 60; k++)
			send_request(random_pixel(k % 10 == 9));
		tx_gaps = 1'b1;
	endtask

	// Let the block run completely dry between bursts.
	task automatic test_drain_pause();
		int round;
		int k;
		for (round = 0; round < 3; round++) begin
			for (k = 0; k < 10; k++) begin
				send_request(random_pixel(k == 9));
				maybe_gap();
			end
			drain_results();
		end
	endtask

	// Result sink: check at the rising edge, choose pop at the falling edge.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				check_result(result);
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				// take over a requested long hold and count it down here
				stall_left = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				stall_left = pick_gap() - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_first_frame_passthrough();
		test_table_load();
		test_blend_extremes();
		test_restart_mid_frame();
		test_unused_func();
		test_random_frames(200);
		test_full_stall();
		test_drain_pause();

		// wait out the last results, then watch for any stray output
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("adaptive_frame_persistence test passed");
		else
			$display("adaptive_frame_persistence test failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#4000000;
		$display("adaptive_frame_persistence test failed");
		$finish;
	end

endmodule
